### hw/rtl/lsu_pkg.sv
// shared constants and types for the legendre symbol unit
package lsu_pkg;

  // default operand widths
  localparam int VALUE_BITS_DEF   = 64;
  localparam int MODULUS_BITS_DEF = 31;

  // result symbol encoding, two's complement
  typedef logic signed [1:0] sym_t;
  localparam sym_t SYM_ZERO = 2'sb00;
  localparam sym_t SYM_POS  = 2'sb01;
  localparam sym_t SYM_NEG  = 2'sb11;

  // residues of the modulus that flip the sign on halving
  localparam logic [2:0] MOD8_FLIP_A = 3'd3;
  localparam logic [2:0] MOD8_FLIP_B = 3'd5;
  // residue mod 4 that takes part in the reciprocity sign rule
  localparam logic [1:0] MOD4_FLIP   = 2'd3;

endpackage

### hw/rtl/legendre_symbol_unit.sv
// top level of the legendre symbol unit: sequencer and shared subtract/shift datapath
//
// Computes the Legendre (Jacobi) symbol of in_value with respect to in_modulus with the
// binary reciprocity algorithm. A transaction is taken when start is high and busy is low;
// one result per transaction appears on the out_ ports for a single cycle with out_valid
// high, and the receiver cannot stall it. A zero modulus or an even modulus other than 2
// gives out_bad_modulus = 1 and symbol 0; moduli 0, 1 and 2 and bad moduli give their
// result in the cycle after start is taken, without raising busy. Any other modulus runs
// one step per cycle through a single shared datapath (one wide compare, one wide
// subtract, one one-bit shift): each step either halves the value or subtracts/swaps
// the pair; busy stays high while the steps run. The result leaves in the cycle after
// the value reaches zero, and busy is low again in that cycle.
module legendre_symbol_unit #(
  parameter int VALUE_BITS   = lsu_pkg::VALUE_BITS_DEF,
  parameter int MODULUS_BITS = lsu_pkg::MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  logic [MODULUS_BITS-1:0] in_modulus,
  output logic                    out_valid,
  output lsu_pkg::sym_t           out_symbol,
  output logic                    out_bad_modulus
);
  import lsu_pkg::*;

  // modulus register needs three bits for the mod-8 rule
  localparam int NW = (MODULUS_BITS < 3) ? 3 : MODULUS_BITS;
  // value register must also hold a difference below the modulus
  localparam int AW = (VALUE_BITS < NW) ? NW : VALUE_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r, state_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          neg_r, neg_nxt;
  logic          out_valid_r, out_valid_nxt;
  sym_t          out_symbol_r, out_symbol_nxt;
  logic          out_bad_r, out_bad_nxt;

  logic          mod_zero, mod_one, mod_two, mod_bad;
  logic [AW-1:0] n_ext;
  logic          a_lt_n;
  logic [AW-1:0] sub_lhs, sub_rhs, diff;
  logic          a_zero, n_one;

  // classification of the incoming modulus
  assign mod_zero = (in_modulus == '0);
  assign mod_one  = (in_modulus == MODULUS_BITS'(1));
  assign mod_two  = (in_modulus == MODULUS_BITS'(2));
  assign mod_bad  = mod_zero || (!in_modulus[0] && !mod_two);

  // shared compare and subtract: a - n, or n - a with a swap when a < n
  assign n_ext   = AW'(n_r);
  assign a_lt_n  = (a_r < n_ext);
  assign sub_lhs = a_lt_n ? n_ext : a_r;
  assign sub_rhs = a_lt_n ? a_r : n_ext;
  assign diff    = sub_lhs - sub_rhs;
  assign a_zero  = (a_r == '0);
  assign n_one   = (n_r == NW'(1));

  // sequencer and one algorithm step per cycle
  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    n_nxt          = n_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_bad_nxt    = out_bad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (mod_bad || mod_zero || mod_one) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = SYM_ZERO;
            out_bad_nxt    = mod_bad;
          end else if (mod_two) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = in_value[0] ? SYM_POS : SYM_ZERO;
            out_bad_nxt    = 1'b0;
          end else begin
            a_nxt     = AW'(in_value);
            n_nxt     = NW'(in_modulus);
            neg_nxt   = 1'b0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (a_zero) begin
          // done: gcd is one exactly when the modulus has reached one
          out_valid_nxt  = 1'b1;
          out_bad_nxt    = 1'b0;
          out_symbol_nxt = n_one ? (neg_r ? SYM_NEG : SYM_POS) : SYM_ZERO;
          state_nxt      = ST_IDLE;
        end else if (!a_r[0]) begin
          // strip a factor of two, mod-8 sign rule
          a_nxt = a_r >> 1;
          if (n_r[2:0] == MOD8_FLIP_A || n_r[2:0] == MOD8_FLIP_B) begin
            neg_nxt = !neg_r;
          end
        end else begin
          // both odd: subtract, swapping first by reciprocity when a < n
          a_nxt = diff;
          if (a_lt_n) begin
            n_nxt = a_r[NW-1:0];
            if (a_r[1:0] == MOD4_FLIP && n_r[1:0] == MOD4_FLIP) begin
              neg_nxt = !neg_r;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    n_r          <= n_nxt;
    neg_r        <= neg_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign busy            = (state_r == ST_RUN);
  assign out_valid       = out_valid_r;
  assign out_symbol      = out_symbol_r;
  assign out_bad_modulus = out_bad_r;

endmodule

### hw/rtl/lsu_checker.sv
// port-level checks for the legendre symbol unit, bound to the top level
module lsu_checker #(
  parameter int VALUE_BITS   = lsu_pkg::VALUE_BITS_DEF,
  parameter int MODULUS_BITS = lsu_pkg::MODULUS_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [VALUE_BITS-1:0]   in_value,
  input logic [MODULUS_BITS-1:0] in_modulus,
  input logic                    out_valid,
  input lsu_pkg::sym_t           out_symbol,
  input logic                    out_bad_modulus
);
  import lsu_pkg::*;

  logic take, bad_in, two_in;

  assign take   = start && !busy;
  assign two_in = (in_modulus == MODULUS_BITS'(2));
  assign bad_in = (in_modulus == '0) || (!in_modulus[0] && !two_in);

  // a flagged modulus always reports symbol zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_modulus |-> out_symbol == SYM_ZERO)
    else $error("bad modulus with nonzero symbol");

  // a bad modulus is answered in the next cycle
  a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
    take && bad_in |=> out_valid && out_bad_modulus)
    else $error("bad modulus not flagged in one cycle");

  // modulus two gives the parity of the value in the next cycle
  a_mod_two: assert property (@(posedge clk) disable iff (!rst_n)
    take && two_in |=> out_valid && !out_bad_modulus &&
      out_symbol == ($past(in_value[0]) ? SYM_POS : SYM_ZERO))
    else $error("wrong result for modulus two");

  // a result never overlaps a running transaction
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // the reserved symbol code never appears
  a_sym_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_symbol != 2'sb10)
    else $error("invalid symbol code");

endmodule

bind legendre_symbol_unit lsu_checker #(
  .VALUE_BITS(VALUE_BITS),
  .MODULUS_BITS(MODULUS_BITS)
) u_lsu_checker (.*);

### dv/legendre_symbol_unit_tb.sv
// self-checking testbench for the legendre symbol unit: directed and random operands
module legendre_symbol_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsu_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int MODULUS_BITS = MODULUS_BITS_DEF;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 2 * (VALUE_BITS + MODULUS_BITS) + 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int MAX_REPORTS   = 10;

  typedef logic [VALUE_BITS-1:0]   value_t;
  typedef logic [MODULUS_BITS-1:0] modulus_t;

  // expected symbol plus the operands that produced it
  typedef struct {
    sym_t     symbol;
    logic     bad_modulus;
    value_t   value;
    modulus_t modulus;
  } symbol_expect_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  value_t   in_value = '0;
  modulus_t in_modulus = '0;
  logic     busy;
  logic     out_valid;
  sym_t     out_symbol;
  logic     out_bad_modulus;

  symbol_expect_t expected_symbols[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  legendre_symbol_unit #(
    .VALUE_BITS  (VALUE_BITS),
    .MODULUS_BITS(MODULUS_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_symbol     (out_symbol),
    .out_bad_modulus(out_bad_modulus)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // jacobi symbol by halving, reduction mod n and reciprocity swaps
  function automatic symbol_expect_t predict_legendre(input value_t value,
                                                      input modulus_t modulus);
    symbol_expect_t exp_sym;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] t;
    int sign;
    bit done;
    exp_sym.value = value;
    exp_sym.modulus = modulus;
    exp_sym.symbol = SYM_ZERO;
    exp_sym.bad_modulus = 1'b0;
    if (modulus == 0 || (!modulus[0] && modulus != 2)) begin
      exp_sym.bad_modulus = 1'b1;
      return exp_sym;
    end
    a = value;
    n = 64'(modulus);
    sign = 1;
    done = 1'b0;
    while (!done) begin
      if (a % n == 0) begin
        done = 1'b1;
      end else if (a == 1) begin
        exp_sym.symbol = (sign > 0) ? SYM_POS : SYM_NEG;
        done = 1'b1;
      end else if (!a[0]) begin
        a = a >> 1;
        if (n[2:0] == MOD8_FLIP_A || n[2:0] == MOD8_FLIP_B) sign = -sign;
      end else if (a > n) begin
        a = a % n;
      end else begin
        if (a[1:0] == MOD4_FLIP && n[1:0] == MOD4_FLIP) sign = -sign;
        t = a;
        a = n;
        n = t;
      end
    end
    return exp_sym;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // one transaction, with an optional idle gap before it
  task automatic send_operands(input value_t value, input modulus_t modulus,
                               input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      in_value <= {$urandom, $urandom};
      in_modulus <= modulus_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= value;
    in_modulus <= modulus;
    do @(posedge clk); while (busy !== 1'b0);
    expected_symbols.push_back(predict_legendre(value, modulus));
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_operands(64'd0, 31'd7, 36);                    // value zero
    send_operands('1, 31'h7FFF_FFFF, 36);               // both fields at maximum
    send_operands(64'd5, 31'd0, 36);                    // zero modulus
    send_operands(64'd5, 31'd4, 36);                    // even modulus
    send_operands('1, 31'h7FFF_FFFE, 36);               // largest even modulus
    send_operands(64'd12345, 31'd1, 36);                // modulus one
    send_operands(64'd6, 31'd2, 36);                    // modulus two, even value
    send_operands(64'd7, 31'd2, 36);                    // modulus two, odd value
    send_operands(64'd2, 31'd7, 36);                    // residue
    send_operands(64'd3, 31'd7, 36);                    // non-residue
    send_operands(64'd2, 31'd3, 36);                    // halving flip, n mod 8 = 3
    send_operands(64'd2, 31'd5, 36);                    // halving flip, n mod 8 = 5
    send_operands(64'd3, 31'd11, 36);                   // reciprocity flip
    send_operands(64'd2, 31'd15, 36);                   // composite modulus
    send_operands(64'd7, 31'd9, 36);                    // square modulus
    send_operands(64'd21, 31'd7, 36);                   // multiple of modulus
    send_operands(64'd1, 31'h7FFF_FFFF, 36);            // value one
    send_operands(64'h8000_0000_0000_0000, 31'd3, 36);  // large power of two
    send_operands(64'd1000003, 31'd1000003, 36);        // value equals modulus
    send_operands(64'hFFFF_FFFF_FFFF_FFFE, 31'd1000003, 36);
    send_operands(64'h5555_5555_AAAA_AAAA, 31'h2AAA_AAAB, 36);
  endtask

  // random operands biased toward valid odd moduli
  task automatic test_random_operands(input int count, input int idle_pct);
    value_t   value;
    modulus_t modulus;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) modulus = modulus_t'($urandom_range(0, 2));
      else if (pick < 14) modulus = modulus_t'($urandom) & ~modulus_t'(1);
      else if (pick < 40) modulus = modulus_t'($urandom_range(1, 2047)) | modulus_t'(1);
      else modulus = modulus_t'($urandom) | modulus_t'(1);
      pick = $urandom_range(99);
      if (pick < 5) value = '0;
      else if (pick < 12) value = value_t'(modulus) * value_t'($urandom);
      else if (pick < 20) value = value_t'($urandom_range(0, 255));
      else if (pick < 25) value = ~value_t'($urandom_range(0, 255));
      else value = {$urandom, $urandom};
      send_operands(value, modulus, idle_pct);
      if (i % 150 == 149) wait_results_drained();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    symbol_expect_t want;
    if (out_valid === 1'b1) begin
      if (expected_symbols.size() == 0) begin
        note_mismatch($sformatf("result with no pending transaction, symbol %0d bad %b",
                                out_symbol, out_bad_modulus));
      end else begin
        want = expected_symbols.pop_front();
        if (out_symbol !== want.symbol)
          note_mismatch($sformatf("symbol for value %h modulus %0d: expected %0d, got %0d",
                                  want.value, want.modulus, want.symbol, out_symbol));
        if (out_bad_modulus !== want.bad_modulus)
          note_mismatch($sformatf("bad_modulus for modulus %0d: expected %b, got %b",
                                  want.modulus, want.bad_modulus, out_bad_modulus));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    wait_results_drained();
    test_random_operands(400, 36);
    test_random_operands(400, 87);
    test_random_operands(400, 0);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_symbols.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
